/* rtl/c128_pkg.sv */
`default_nettype none
package c128_pkg;

    localparam int SYM_DEPTH = 64;
    localparam int SAW       = 6;

    // Character codes of the input stream.
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_NUL   = 8'd128;
    localparam logic [7:0] CH_FNC1  = 8'd129;
    localparam logic [7:0] CH_FNC2  = 8'd130;
    localparam logic [7:0] CH_FNC3  = 8'd131;
    localparam logic [7:0] CH_LAST  = 8'd132;

    // Symbol values with a fixed meaning.
    localparam logic [6:0] SYM_FNC3    = 7'd96;
    localparam logic [6:0] SYM_FNC2    = 7'd97;
    localparam logic [6:0] SYM_CODE_C  = 7'd99;
    localparam logic [6:0] SYM_CODE_B  = 7'd100;
    localparam logic [6:0] SYM_CODE_A  = 7'd101;
    localparam logic [6:0] SYM_FNC1    = 7'd102;
    localparam logic [6:0] SYM_START_A = 7'd103;
    localparam logic [6:0] SYM_STOP    = 7'd106;
    localparam logic [6:0] SYM_ZONE    = 7'd127;
    localparam logic [6:0] SYM_NUL_A   = 7'd64;
    localparam logic [7:0] CHK_MOD     = 8'd103;
    localparam int         NUM_SYMS    = 107;

    localparam logic [1:0] LINK_AB = 2'd1;
    localparam logic [1:0] LINK_C  = 2'd2;

    // Bar and space widths of each symbol, five octal digits, first bar highest.
    localparam logic [14:0] WIDTH_CODE [NUM_SYMS] = '{
        15'o21222,15'o22212,15'o22222,15'o12122,15'o12132,15'o13122,15'o12221,15'o12231,
        15'o13221,15'o22121,15'o22131,15'o23121,15'o11223,15'o12213,15'o12223,15'o11322,
        15'o12312,15'o12322,15'o22321,15'o22113,15'o22123,15'o21321,15'o22311,15'o31213,
        15'o31122,15'o32112,15'o32122,15'o31221,15'o32211,15'o32221,15'o21212,15'o21232,
        15'o23212,15'o11132,15'o13112,15'o13132,15'o11231,15'o13211,15'o13231,15'o21131,
        15'o23111,15'o23131,15'o11213,15'o11233,15'o13213,15'o11312,15'o11332,15'o13312,
        15'o31312,15'o21133,15'o23113,15'o21311,15'o21331,15'o21313,15'o31112,15'o31132,
        15'o33112,15'o31211,15'o31231,15'o33211,15'o31411,15'o22141,15'o43111,15'o11122,
        15'o11142,15'o12112,15'o12142,15'o14112,15'o14122,15'o11221,15'o11241,15'o12211,
        15'o12241,15'o14211,15'o14221,15'o24121,15'o22111,15'o41311,15'o24111,15'o13411,
        15'o11124,15'o12114,15'o12124,15'o11421,15'o12411,15'o12421,15'o41121,15'o42111,
        15'o42121,15'o21214,15'o21412,15'o41212,15'o11114,15'o11134,15'o13114,15'o11411,
        15'o11431,15'o41111,15'o41131,15'o11314,15'o11413,15'o31114,15'o41113,15'o21141,
        15'o21121,15'o21123,15'o23311
    };

    typedef enum logic [1:0] {SET_A = 2'd0, SET_B = 2'd1, SET_C = 2'd2} t_set;

    typedef enum logic [2:0] {RD_NONE, RD_ZERO, RD_PTR, RD_DI, RD_DI1} t_rd_src;
    typedef enum logic [2:0] {P_HOLD, P_D0, P_DI, P_INC, P_REWIND} t_ptr_op;
    typedef enum logic [1:0] {R_HOLD, R_CLR, R_INC} t_run_op;
    typedef enum logic [2:0] {S_HOLD, S_A, S_B, S_C, S_PICK} t_set_op;
    typedef enum logic [3:0] {
        PU_NONE, PU_START, PU_PAIR, PU_FNC1, PU_SW_C, PU_C, PU_B, PU_A,
        PU_MAPA, PU_MAPB, PU_LINK, PU_CHECK, PU_STOP
    } t_push;
    typedef enum logic [1:0] {D_HOLD, D_CLR, D_INC, D_INC2} t_di_op;
    typedef enum logic [1:0] {CK_HOLD, CK_INIT, CK_STEP, CK_LAST} t_ck_op;
    typedef enum logic [2:0] {SI_HOLD, SI_TOP, SI_DEC, SI_INC, SI_CLR} t_si_op;
    typedef enum logic [1:0] {O_NONE, O_QUIET, O_SYM, O_TRAIL} t_out_op;

    typedef struct packed {
        logic    load;
        t_rd_src rd_src;
        t_ptr_op ptr_op;
        t_run_op run_op;
        t_set_op set_op;
        t_push   push;
        t_di_op  di_op;
        logic    cap_c0;
        logic    cap_c1;
        t_ck_op  ck_op;
        t_si_op  si_op;
        logic    sread;
        t_out_op out_op;
        logic    fin;
        logic    clr_msg;
    } t_cmd;

    typedef struct packed {
        logic ptr_lt_n;
        logic ptr_eq_n;
        logic di_lt_n;
        logic sc_lt_lim;
        logic rd_digit;
        logic rd_cont;
        logic run_ge4;
        logic run_eq2;
        logic run_sw;
        t_set set;
        logic c_pair;
        logic c_fnc1;
        logic c_lower;
        logic c_ctl;
        logic link_on;
        logic si_zero;
        logic si_lt_sc;
        logic out_free;
    } t_stat;

    typedef enum logic [4:0] {
        ST_LOAD, ST_RD0, ST_D0, ST_DS_REQ, ST_DS_CHK, ST_INIT_DEC, ST_PK_REQ, ST_PK_CHK,
        ST_START, ST_LOOP, ST_LA, ST_LB, ST_LC, ST_LD, ST_AB_DEC, ST_C_SW, ST_FIN,
        ST_CK_INIT, ST_CK_REQ, ST_CK_ACC, ST_CK_PUSH, ST_STOP, ST_EM_Q, ST_EM_REQ,
        ST_EM_LD, ST_EM_TR
    } t_state;

endpackage
`default_nettype wire

/* rtl/code128_symbol_encoder.sv */
`default_nettype none
// Channel     Direction  Handshake                  Payload
// s (chars)   in         i_s_tvalid / o_s_tready    i_s_tdata, i_s_tlast
// m (items)   out        o_m_tvalid / i_m_tready    o_m_tdata, o_m_tlast
// cfg         in         i_cfg_wen                  i_cfg_wdata (link mode)
//
// Characters are taken one per cycle while the block is collecting a message.
// Once the last character is in, encoding runs out of the character buffer,
// which has a single registered read port; the check character is then summed
// over the symbol buffer, and emission follows while the sink takes the results,
// each symbol being read from the symbol buffer before its result is loaded.
// Reset is synchronous and active low and leaves the block ready for a message.
// A stalled sink holds the result register; input is accepted again as soon as
// the trailer has been loaded into it.
module code128_symbol_encoder #(
    parameter int MAX_SYMBOLS = 60,
    parameter int MAX_CHARS   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire logic        i_s_tlast,   // last_char
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [6:0] symbol_value, [10:7] width_0, [14:11] width_1, [17:15] width_2,
    // [20:18] width_3, [23:21] width_4, [26:24] width_5, [29:27] element_count,
    // [35:30] total_symbols, [36] truncated, [39:37] zero
    output logic [39:0]      o_m_tdata,
    output logic             o_m_tlast,   // last_item
    input  wire logic        i_cfg_wen,
    input  wire logic [1:0]  i_cfg_wdata  // link_mode
);
    import c128_pkg::*;

    // The controller sequences load, start-set choice, conversion, check and
    // emission; the datapath holds both buffers and all arithmetic.
    t_cmd  cmd;
    t_stat stat;

    c128_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_last  (i_s_tlast),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    c128_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .MAX_CHARS   (MAX_CHARS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_char      (i_s_tdata),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );
endmodule
`default_nettype wire

/* rtl/c128_ctrl.sv */
`default_nettype none
module c128_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_last,
    output logic                o_in_ready,
    input  wire c128_pkg::t_stat i_stat,
    output c128_pkg::t_cmd      o_cmd
);
    import c128_pkg::*;

    t_state r_state, n_state;
    // Context of a look-ahead scan: 0 while choosing the start set, 1 inside the data loop.
    logic   r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ret   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                o_cmd.rd_src = RD_ZERO;
                n_state      = ST_D0;
            end
            ST_D0: begin
                o_cmd.ptr_op = P_D0;
                o_cmd.run_op = R_CLR;
                n_ret        = 1'b0;
                n_state      = ST_DS_REQ;
            end
            ST_DS_REQ: begin
                if (i_stat.ptr_lt_n) begin
                    o_cmd.rd_src = RD_PTR;
                    n_state      = ST_DS_CHK;
                end else begin
                    n_state = r_ret ? ST_AB_DEC : ST_INIT_DEC;
                end
            end
            ST_DS_CHK: begin
                if (i_stat.rd_digit) begin
                    o_cmd.ptr_op = P_INC;
                    o_cmd.run_op = R_INC;
                    n_state      = ST_DS_REQ;
                end else begin
                    n_state = r_ret ? ST_AB_DEC : ST_INIT_DEC;
                end
            end
            ST_INIT_DEC: begin
                if (i_stat.run_ge4 || (i_stat.run_eq2 && i_stat.ptr_eq_n)) begin
                    o_cmd.set_op = S_C;
                    n_state      = ST_START;
                end else begin
                    o_cmd.ptr_op = P_REWIND;
                    n_state      = ST_PK_REQ;
                end
            end
            ST_PK_REQ: begin
                if (i_stat.ptr_lt_n) begin
                    o_cmd.rd_src = RD_PTR;
                    n_state      = ST_PK_CHK;
                end else begin
                    o_cmd.set_op = S_A;
                    n_state      = r_ret ? ST_C_SW : ST_START;
                end
            end
            ST_PK_CHK: begin
                if (i_stat.rd_cont) begin
                    o_cmd.ptr_op = P_INC;
                    n_state      = ST_PK_REQ;
                end else begin
                    o_cmd.set_op = S_PICK;
                    n_state      = r_ret ? ST_C_SW : ST_START;
                end
            end
            ST_START: begin
                o_cmd.push  = PU_START;
                o_cmd.di_op = D_CLR;
                n_state     = ST_LOOP;
            end
            ST_LOOP: begin
                n_state = (i_stat.di_lt_n && i_stat.sc_lt_lim) ? ST_LA : ST_FIN;
            end
            ST_LA: begin
                o_cmd.rd_src = RD_DI;
                n_state      = ST_LB;
            end
            ST_LB: begin
                o_cmd.cap_c0 = 1'b1;
                o_cmd.rd_src = RD_DI1;
                n_state      = ST_LC;
            end
            ST_LC: begin
                o_cmd.cap_c1 = 1'b1;
                n_state      = ST_LD;
            end
            ST_LD: begin
                n_ret = 1'b1;
                if (i_stat.set == SET_C) begin
                    if (i_stat.c_pair) begin
                        o_cmd.push  = PU_PAIR;
                        o_cmd.di_op = D_INC2;
                        n_state     = ST_LOOP;
                    end else if (i_stat.c_fnc1) begin
                        o_cmd.push  = PU_FNC1;
                        o_cmd.di_op = D_INC;
                        n_state     = ST_LOOP;
                    end else begin
                        o_cmd.ptr_op = P_DI;
                        n_state      = ST_PK_REQ;
                    end
                end else begin
                    o_cmd.ptr_op = P_DI;
                    o_cmd.run_op = R_CLR;
                    n_state      = ST_DS_REQ;
                end
            end
            ST_AB_DEC: begin
                n_state = ST_LOOP;
                if (i_stat.run_sw) begin
                    o_cmd.set_op = S_C;
                    o_cmd.push   = PU_C;
                end else if (i_stat.set == SET_A) begin
                    if (i_stat.c_lower) begin
                        o_cmd.set_op = S_B;
                        o_cmd.push   = PU_B;
                    end else begin
                        o_cmd.push  = PU_MAPA;
                        o_cmd.di_op = D_INC;
                    end
                end else begin
                    if (i_stat.c_ctl) begin
                        o_cmd.set_op = S_A;
                        o_cmd.push   = PU_A;
                    end else begin
                        o_cmd.push  = PU_MAPB;
                        o_cmd.di_op = D_INC;
                    end
                end
            end
            ST_C_SW: begin
                o_cmd.push = PU_SW_C;
                n_state    = ST_LOOP;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                if (i_stat.link_on) begin
                    o_cmd.push = PU_LINK;
                end
                n_state = ST_CK_INIT;
            end
            ST_CK_INIT: begin
                o_cmd.ck_op = CK_INIT;
                o_cmd.si_op = SI_TOP;
                n_state     = ST_CK_REQ;
            end
            ST_CK_REQ: begin
                o_cmd.sread = 1'b1;
                n_state     = ST_CK_ACC;
            end
            ST_CK_ACC: begin
                if (!i_stat.si_zero) begin
                    o_cmd.ck_op = CK_STEP;
                    o_cmd.si_op = SI_DEC;
                    n_state     = ST_CK_REQ;
                end else begin
                    o_cmd.ck_op = CK_LAST;
                    n_state     = ST_CK_PUSH;
                end
            end
            ST_CK_PUSH: begin
                o_cmd.push = PU_CHECK;
                n_state    = ST_STOP;
            end
            ST_STOP: begin
                o_cmd.push  = PU_STOP;
                o_cmd.si_op = SI_CLR;
                n_state     = ST_EM_Q;
            end
            ST_EM_Q: begin
                if (i_stat.out_free) begin
                    o_cmd.out_op = O_QUIET;
                    n_state      = ST_EM_REQ;
                end
            end
            ST_EM_REQ: begin
                if (i_stat.si_lt_sc) begin
                    o_cmd.sread = 1'b1;
                    n_state     = ST_EM_LD;
                end else begin
                    n_state = ST_EM_TR;
                end
            end
            ST_EM_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_op = O_SYM;
                    o_cmd.si_op  = SI_INC;
                    n_state      = ST_EM_REQ;
                end
            end
            ST_EM_TR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_op  = O_TRAIL;
                    o_cmd.clr_msg = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/c128_dp.sv */
`default_nettype none
module c128_dp #(
    parameter int MAX_SYMBOLS = 60,
    parameter int MAX_CHARS   = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire c128_pkg::t_cmd  i_cmd,
    output c128_pkg::t_stat      o_stat,
    input  wire logic [7:0]      i_char,
    input  wire logic            i_cfg_wen,
    input  wire logic [1:0]      i_cfg_wdata,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output logic [39:0]          o_m_tdata,
    output logic                 o_m_tlast
);
    import c128_pkg::*;

    localparam int CNW = $clog2(MAX_CHARS + 1);
    localparam int CAW = $clog2(MAX_CHARS);

    logic [7:0]     r_cmem [MAX_CHARS];
    logic [6:0]     r_smem [SYM_DEPTH];

    logic [CNW-1:0] r_n, r_ptr, r_di, r_run;
    logic           r_ovf;
    logic [7:0]     r_rd, r_c0, r_c1;
    t_set           r_set;
    logic [SAW-1:0] r_sc, r_si;
    logic [6:0]     r_sd, r_t, r_acc;
    logic [1:0]     r_link;

    logic           r_ovalid;
    logic [6:0]     r_osv;
    logic [3:0]     r_ow0, r_ow1;
    logic [2:0]     r_ow2, r_ow3, r_ow4, r_ow5, r_oec;
    logic [5:0]     r_ots;
    logic           r_otr, r_olast;

    // Character intake and buffer ports.
    logic [7:0]     cin;
    logic           cvalid, cfull, wr_en, rd_ok;
    logic [CNW:0]   raddr;

    assign cin    = (i_char == CH_HASH) ? CH_FNC1 : i_char;
    assign cvalid = (cin != 8'd0) && (cin <= CH_LAST);
    assign cfull  = (r_n >= CNW'(MAX_CHARS));
    assign wr_en  = i_cmd.load && cvalid && !cfull;

    always_comb begin
        case (i_cmd.rd_src)
            RD_ZERO: raddr = '0;
            RD_PTR:  raddr = {1'b0, r_ptr};
            RD_DI:   raddr = {1'b0, r_di};
            RD_DI1:  raddr = {1'b0, r_di} + (CNW+1)'(1);
            default: raddr = '0;
        endcase
    end
    assign rd_ok = (i_cmd.rd_src != RD_NONE) && (raddr < (CNW+1)'(MAX_CHARS));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cmem[r_n[CAW-1:0]] <= cin;
        end
        if (rd_ok) begin
            r_rd <= r_cmem[raddr[CAW-1:0]];
        end
    end

    // Classification of characters.
    logic rd_digit, c0_digit, c1_digit, di1_lt_n;
    assign rd_digit = r_rd inside {[8'd48:8'd57]};
    assign c0_digit = r_c0 inside {[8'd48:8'd57]};
    assign c1_digit = r_c1 inside {[8'd48:8'd57]};
    assign di1_lt_n = ({1'b0, r_di} + (CNW+1)'(1)) < {1'b0, r_n};

    // Symbol values for sets A and B, set C pairs and the link character.
    logic [6:0] fnc_a, fnc_b, map_a, map_b, pair, link_v, push_v;
    always_comb begin
        case (r_c0)
            CH_FNC1: begin fnc_a = SYM_FNC1; fnc_b = SYM_FNC1; end
            CH_FNC2: begin fnc_a = SYM_FNC2; fnc_b = SYM_FNC2; end
            CH_FNC3: begin fnc_a = SYM_FNC3; fnc_b = SYM_FNC3; end
            default: begin fnc_a = SYM_CODE_A; fnc_b = SYM_CODE_B; end
        endcase
        if (r_c0 < 8'd32)       map_a = r_c0[6:0] + 7'd64;
        else if (r_c0 < 8'd96)  map_a = r_c0[6:0] - 7'd32;
        else if (r_c0 == CH_NUL) map_a = SYM_NUL_A;
        else                    map_a = fnc_a;
        map_b = (r_c0 < 8'd128) ? (r_c0[6:0] - 7'd32) : fnc_b;
        pair  = {r_c0[3:0], 3'b000} + {2'b00, r_c0[3:0], 1'b0} + {3'b000, r_c1[3:0]};
        case (r_set)
            SET_A:   link_v = (r_link == LINK_AB) ? SYM_CODE_B : SYM_CODE_C;
            SET_B:   link_v = (r_link == LINK_AB) ? SYM_CODE_C : SYM_CODE_A;
            default: link_v = (r_link == LINK_AB) ? SYM_CODE_A : SYM_CODE_B;
        endcase
    end

    // Modulo-103 arithmetic of the check character, done last index first:
    // a running suffix sum added once per position gives the weighted sum.
    logic [6:0] vr, tn, an, a0;
    logic [7:0] t1, a1, a2;
    assign vr = ({1'b0, r_sd} >= CHK_MOD) ? (r_sd - CHK_MOD[6:0]) : r_sd;
    assign t1 = {1'b0, r_t} + {1'b0, vr};
    assign tn = (t1 >= CHK_MOD) ? 7'(t1 - CHK_MOD) : t1[6:0];
    assign a1 = {1'b0, r_acc} + {1'b0, tn};
    assign an = (a1 >= CHK_MOD) ? 7'(a1 - CHK_MOD) : a1[6:0];
    assign a2 = {1'b0, r_acc} + {1'b0, vr};
    assign a0 = (a2 >= CHK_MOD) ? 7'(a2 - CHK_MOD) : a2[6:0];

    always_comb begin
        case (i_cmd.push)
            PU_START: push_v = SYM_START_A + {5'd0, r_set};
            PU_PAIR:  push_v = pair;
            PU_FNC1:  push_v = SYM_FNC1;
            PU_SW_C:  push_v = (r_set == SET_A) ? SYM_CODE_A : SYM_CODE_B;
            PU_C:     push_v = SYM_CODE_C;
            PU_B:     push_v = SYM_CODE_B;
            PU_A:     push_v = SYM_CODE_A;
            PU_MAPA:  push_v = map_a;
            PU_MAPB:  push_v = map_b;
            PU_LINK:  push_v = link_v;
            PU_CHECK: push_v = r_acc;
            PU_STOP:  push_v = SYM_STOP;
            default:  push_v = SYM_STOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push != PU_NONE) begin
            r_smem[(i_cmd.push == PU_START) ? '0 : r_sc] <= push_v;
        end
        if (i_cmd.sread) begin
            r_sd <= r_smem[r_si];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_ovf    <= 1'b0;
            r_set    <= SET_A;
            r_sc     <= '0;
            r_link   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_link <= i_cfg_wdata;
            end
            if (i_cmd.clr_msg) begin
                r_n   <= '0;
                r_ovf <= 1'b0;
            end else if (i_cmd.load && cvalid) begin
                if (cfull) r_ovf <= 1'b1;
                else       r_n   <= r_n + CNW'(1);
            end else if (i_cmd.fin && (r_di < r_n)) begin
                r_ovf <= 1'b1;
            end
            case (i_cmd.set_op)
                S_A:     r_set <= SET_A;
                S_B:     r_set <= SET_B;
                S_C:     r_set <= SET_C;
                S_PICK:  r_set <= ((r_rd < 8'd32) || (r_rd == CH_NUL)) ? SET_A : SET_B;
                default: r_set <= r_set;
            endcase
            if (i_cmd.push == PU_START)    r_sc <= SAW'(1);
            else if (i_cmd.push != PU_NONE) r_sc <= r_sc + SAW'(1);
            if (i_cmd.out_op != O_NONE) r_ovalid <= 1'b1;
            else if (i_m_tready)        r_ovalid <= 1'b0;
        end
    end

    // Scan, position and check registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.ptr_op)
            P_D0:     r_ptr <= ((r_n != '0) && (r_rd == CH_FNC1)) ? CNW'(1) : '0;
            P_DI:     r_ptr <= r_di;
            P_INC:    r_ptr <= r_ptr + CNW'(1);
            P_REWIND: r_ptr <= r_ptr - r_run;
            default:  r_ptr <= r_ptr;
        endcase
        case (i_cmd.run_op)
            R_CLR:   r_run <= '0;
            R_INC:   r_run <= r_run + CNW'(1);
            default: r_run <= r_run;
        endcase
        case (i_cmd.di_op)
            D_CLR:   r_di <= '0;
            D_INC:   r_di <= r_di + CNW'(1);
            D_INC2:  r_di <= r_di + CNW'(2);
            default: r_di <= r_di;
        endcase
        if (i_cmd.cap_c0) r_c0 <= r_rd;
        if (i_cmd.cap_c1) r_c1 <= di1_lt_n ? r_rd : 8'd0;
        case (i_cmd.ck_op)
            CK_INIT: begin
                r_t   <= '0;
                r_acc <= '0;
            end
            CK_STEP: begin
                r_t   <= tn;
                r_acc <= an;
            end
            CK_LAST: r_acc <= a0;
            default: r_acc <= r_acc;
        endcase
        case (i_cmd.si_op)
            SI_TOP:  r_si <= r_sc - SAW'(1);
            SI_DEC:  r_si <= r_si - SAW'(1);
            SI_INC:  r_si <= r_si + SAW'(1);
            SI_CLR:  r_si <= '0;
            default: r_si <= r_si;
        endcase
    end

    // Widths of the symbol being emitted.
    logic [14:0] wc;
    logic [5:0]  wsum;
    assign wc   = WIDTH_CODE[(r_sd < 7'(NUM_SYMS)) ? r_sd : SYM_STOP];
    assign wsum = 6'(wc[14:12]) + 6'(wc[11:9]) + 6'(wc[8:6]) + 6'(wc[5:3]) + 6'(wc[2:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_op != O_NONE) begin
            r_ots <= r_sc;
            r_otr <= r_ovf;
            case (i_cmd.out_op)
                O_SYM: begin
                    r_osv   <= r_sd;
                    r_ow0   <= {1'b0, wc[14:12]};
                    r_ow1   <= {1'b0, wc[11:9]};
                    r_ow2   <= wc[8:6];
                    r_ow3   <= wc[5:3];
                    r_ow4   <= wc[2:0];
                    r_ow5   <= (wsum <= 6'd11) ? 3'(6'd11 - wsum) : 3'd0;
                    r_oec   <= 3'd6;
                    r_olast <= 1'b0;
                end
                O_TRAIL: begin
                    r_osv   <= SYM_ZONE;
                    r_ow0   <= 4'd2;
                    r_ow1   <= 4'd10;
                    r_ow2   <= '0;
                    r_ow3   <= '0;
                    r_ow4   <= '0;
                    r_ow5   <= '0;
                    r_oec   <= 3'd2;
                    r_olast <= 1'b1;
                end
                default: begin
                    r_osv   <= SYM_ZONE;
                    r_ow0   <= 4'd10;
                    r_ow1   <= '0;
                    r_ow2   <= '0;
                    r_ow3   <= '0;
                    r_ow4   <= '0;
                    r_ow5   <= '0;
                    r_oec   <= 3'd1;
                    r_olast <= 1'b0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {3'b000, r_otr, r_ots, r_oec, r_ow5, r_ow4, r_ow3, r_ow2,
                         r_ow1, r_ow0, r_osv};

    assign o_stat.ptr_lt_n  = r_ptr < r_n;
    assign o_stat.ptr_eq_n  = r_ptr == r_n;
    assign o_stat.di_lt_n   = r_di < r_n;
    assign o_stat.sc_lt_lim = r_sc < SAW'(MAX_SYMBOLS - 2);
    assign o_stat.rd_digit  = rd_digit;
    assign o_stat.rd_cont   = (r_rd >= 8'd32) && ((r_rd <= 8'd95) || (r_rd >= CH_FNC1));
    assign o_stat.run_ge4   = r_run >= CNW'(4);
    assign o_stat.run_eq2   = r_run == CNW'(2);
    assign o_stat.run_sw    = (r_run >= CNW'(4)) && !r_run[0];
    assign o_stat.set       = r_set;
    assign o_stat.c_pair    = c0_digit && c1_digit && di1_lt_n;
    assign o_stat.c_fnc1    = r_c0 == CH_FNC1;
    assign o_stat.c_lower   = (r_c0 > 8'd95) && (r_c0 < 8'd128);
    assign o_stat.c_ctl     = (r_c0 < 8'd32) || (r_c0 == CH_NUL);
    assign o_stat.link_on   = (r_link == LINK_AB) || (r_link == LINK_C);
    assign o_stat.si_zero   = r_si == '0;
    assign o_stat.si_lt_sc  = r_si < r_sc;
    assign o_stat.out_free  = !r_ovalid || i_m_tready;
endmodule
`default_nettype wire

/* bench/code128_symbol_encoder_tb.sv */
`default_nettype none
module code128_symbol_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c128_pkg::*;

    localparam int CHAR_DEPTH = 64;   // characters the block can hold per message
    localparam int SYM_LIMIT  = 60;   // symbol characters per message, start and stop included, link not counted

    // One output request of the encoder, split into its fields.
    typedef struct {
        logic [6:0] sym;
        logic [3:0] w0;
        logic [3:0] w1;
        logic [2:0] w2;
        logic [2:0] w3;
        logic [2:0] w4;
        logic [2:0] w5;
        logic [2:0] elems;
        logic [5:0] total;
        logic       trunc;
        logic       last;
    } bar_item_t;

    // Directed messages: text, whether the message is closed by an invalid code 0
    // carrying the last flag, the link mode in force, and the symbol count where
    // it is obvious (-1 otherwise).
    typedef struct {
        string text;
        bit    null_end;
        int    link;
        int    want_total;
    } msg_row_t;

    // Bar and space pattern of every symbol value, five octal digits, first bar highest.
    localparam logic [14:0] BAR_PATTERN [107] = '{
        15'o21222,15'o22212,15'o22222,15'o12122,15'o12132,15'o13122,15'o12221,15'o12231,
        15'o13221,15'o22121,15'o22131,15'o23121,15'o11223,15'o12213,15'o12223,15'o11322,
        15'o12312,15'o12322,15'o22321,15'o22113,15'o22123,15'o21321,15'o22311,15'o31213,
        15'o31122,15'o32112,15'o32122,15'o31221,15'o32211,15'o32221,15'o21212,15'o21232,
        15'o23212,15'o11132,15'o13112,15'o13132,15'o11231,15'o13211,15'o13231,15'o21131,
        15'o23111,15'o23131,15'o11213,15'o11233,15'o13213,15'o11312,15'o11332,15'o13312,
        15'o31312,15'o21133,15'o23113,15'o21311,15'o21331,15'o21313,15'o31112,15'o31132,
        15'o33112,15'o31211,15'o31231,15'o33211,15'o31411,15'o22141,15'o43111,15'o11122,
        15'o11142,15'o12112,15'o12142,15'o14112,15'o14122,15'o11221,15'o11241,15'o12211,
        15'o12241,15'o14211,15'o14221,15'o24121,15'o22111,15'o41311,15'o24111,15'o13411,
        15'o11124,15'o12114,15'o12124,15'o11421,15'o12411,15'o12421,15'o41121,15'o42111,
        15'o42121,15'o21214,15'o21412,15'o41212,15'o11114,15'o11134,15'o13114,15'o11411,
        15'o11431,15'o41111,15'o41131,15'o11314,15'o11413,15'o31114,15'o41113,15'o21141,
        15'o21121,15'o21123,15'o23311
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] char_code
    logic        i_s_tlast;    // last_char
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;    // [6:0] symbol_value .. [36] truncated, see the block
    logic        o_m_tlast;    // last_item
    logic        i_cfg_wen;
    logic [1:0]  i_cfg_wdata;  // link_mode

    code128_symbol_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow state of the encoder: the message collected so far, its overflow flag
    // and the link mode register.
    logic [7:0] msg_chars [$];
    bit         msg_overflow;
    logic [1:0] link_mode;

    // Bar items still owed by the block, oldest first.
    bar_item_t  pending_bars [$];
    int         bars_queued;     // bar items ever predicted, never decremented
    int         error_count;
    bit         calm;            // no idling on either side once set
    int         counted_chars;   // valid characters sent, noise excluded

    task automatic report(input string field, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    function automatic bit is_digit(input int k);
        return k < msg_chars.size() && msg_chars[k] >= "0" && msg_chars[k] <= "9";
    endfunction

    function automatic int digits_from(input int k);
        int j;
        j = k;
        while (is_digit(j)) j++;
        return j - k;
    endfunction

    // Set A (0) when a control character, NUL or the end comes before any
    // lower case letter, set B (1) otherwise.
    function automatic logic [1:0] choose_ab(input int k);
        int         j;
        logic [7:0] c;
        j = k;
        while (j < msg_chars.size()) begin
            c = msg_chars[j];
            if (!(c >= 32 && (c <= 95 || c >= 129))) break;
            j++;
        end
        if (j >= msg_chars.size()) return 2'd0;
        c = msg_chars[j];
        return (c < 32 || c == CH_NUL) ? 2'd0 : 2'd1;
    endfunction

    function automatic logic [6:0] fnc_symbol(input logic [7:0] c, input logic [6:0] fnc4);
        case (c)
            CH_FNC1: return SYM_FNC1;
            CH_FNC2: return SYM_FNC2;
            CH_FNC3: return SYM_FNC3;
            default: return fnc4;
        endcase
    endfunction

    // Turns the collected message into symbol values and queues the bar items
    // the block must produce for it.
    function automatic void encode_message();
        logic [6:0] syms [$];
        logic [1:0] cur_set;
        logic [7:0] c;
        bar_item_t  item;
        logic [14:0] pat;
        int n, di, first, run, acc, sum;
        n = msg_chars.size();
        di = 0;
        first = (n > 0 && msg_chars[0] == CH_FNC1) ? 1 : 0;
        run = digits_from(first);
        if (run >= 4 || (run == 2 && first + 2 == n)) cur_set = SET_C;
        else cur_set = choose_ab(first);
        syms.push_back(SYM_START_A + cur_set);

        while (di < n && syms.size() < SYM_LIMIT - 2) begin
            c = msg_chars[di];
            if (cur_set == SET_C) begin
                if (is_digit(di) && is_digit(di + 1)) begin
                    syms.push_back(7'((c & 8'hF) * 10 + (msg_chars[di + 1] & 8'hF)));
                    di += 2;
                end else if (c == CH_FNC1) begin
                    syms.push_back(SYM_FNC1);
                    di++;
                end else begin
                    cur_set = choose_ab(di);
                    syms.push_back(cur_set == SET_A ? SYM_CODE_A : SYM_CODE_B);
                end
            end else begin
                run = digits_from(di);
                if (run > 3 && run % 2 == 0) begin
                    cur_set = SET_C;
                    syms.push_back(SYM_CODE_C);
                end else if (cur_set == SET_A) begin
                    if (c > 95 && c < 128) begin
                        cur_set = SET_B;
                        syms.push_back(SYM_CODE_B);
                    end else begin
                        if (c < 32) syms.push_back(7'(c + 64));
                        else if (c < 96) syms.push_back(7'(c - 32));
                        else if (c == CH_NUL) syms.push_back(SYM_NUL_A);
                        else syms.push_back(fnc_symbol(c, SYM_CODE_A));
                        di++;
                    end
                end else begin
                    if (c < 32 || c == CH_NUL) begin
                        cur_set = SET_A;
                        syms.push_back(SYM_CODE_A);
                    end else begin
                        if (c < 128) syms.push_back(7'(c - 32));
                        else syms.push_back(fnc_symbol(c, SYM_CODE_B));
                        di++;
                    end
                end
            end
        end
        if (di < n) msg_overflow = 1'b1;

        // The link character depends on the set in force at the end of the data.
        if (link_mode == LINK_AB) begin
            syms.push_back(cur_set == SET_A ? SYM_CODE_B :
                           cur_set == SET_B ? SYM_CODE_C : SYM_CODE_A);
        end else if (link_mode == LINK_C) begin
            syms.push_back(cur_set == SET_A ? SYM_CODE_C :
                           cur_set == SET_B ? SYM_CODE_A : SYM_CODE_B);
        end

        acc = syms[0] % 103;
        for (int i = 1; i < syms.size(); i++) acc = (acc + syms[i] * i) % 103;
        syms.push_back(7'(acc));
        syms.push_back(SYM_STOP);

        // Leading quiet zone, one item per symbol, then guard bar and quiet zone.
        item = '{sym: SYM_ZONE, w0: 4'd10, elems: 3'd1, total: 6'(syms.size()),
                 trunc: msg_overflow, default: '0};
        pending_bars.push_back(item);
        foreach (syms[i]) begin
            pat = BAR_PATTERN[syms[i]];
            item.sym = syms[i];
            item.w0 = 4'(pat[14:12]);
            item.w1 = 4'(pat[11:9]);
            item.w2 = pat[8:6];
            item.w3 = pat[5:3];
            item.w4 = pat[2:0];
            sum = pat[14:12] + pat[11:9] + pat[8:6] + pat[5:3] + pat[2:0];
            item.w5 = 3'(11 - sum);
            item.elems = 3'd6;
            pending_bars.push_back(item);
        end
        item = '{sym: SYM_ZONE, w0: 4'd2, w1: 4'd10, elems: 3'd2, total: 6'(syms.size()),
                 trunc: msg_overflow, last: 1'b1, default: '0};
        pending_bars.push_back(item);
        bars_queued += syms.size() + 2;
        msg_chars.delete();
        msg_overflow = 1'b0;
    endfunction

    // Bookkeeping for one accepted character request.
    function automatic void take_char(input logic [7:0] code, input bit last);
        logic [7:0] c;
        c = (code == CH_HASH) ? CH_FNC1 : code;
        if (c >= 1 && c <= CH_LAST) begin
            if (msg_chars.size() < CHAR_DEPTH) msg_chars.push_back(c);
            else msg_overflow = 1'b1;
        end
        if (last) encode_message();
    endfunction

    // Drives one character and waits for the block to take it. The valid stays
    // high after acceptance so that back-to-back requests need no extra step.
    task automatic send_char(input logic [7:0] code, input bit last);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        take_char(code, last);
        if (code >= 1 && code <= CH_LAST) counted_chars++;
    endtask

    // Lowers the source, lets every owed item arrive and lets the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (pending_bars.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_link(input logic [1:0] mode);
        drain();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        link_mode = mode;
    endtask

    // Picks one character from a rough mix of the classes the encoder treats apart.
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return 8'($urandom_range(48, 57));
        if (pick < 55) return 8'($urandom_range(32, 95));
        if (pick < 70) return 8'($urandom_range(96, 127));
        if (pick < 80) return 8'($urandom_range(1, 31));
        if (pick < 92) return 8'($urandom_range(128, 132));
        if (pick < 95) return CH_HASH;
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: random stalls, and a field by field check of every accepted request.
    int stall_left;
    always @(negedge i_clk) begin
        if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        bar_item_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bars.size() == 0) begin
                report("unexpected bar item, symbol_value", o_m_tdata[6:0], -1);
            end else begin
                want = pending_bars.pop_front();
                if (o_m_tdata[6:0] !== want.sym) report("symbol_value", o_m_tdata[6:0], want.sym);
                if (o_m_tdata[10:7] !== want.w0) report("width_0", o_m_tdata[10:7], want.w0);
                if (o_m_tdata[14:11] !== want.w1) report("width_1", o_m_tdata[14:11], want.w1);
                if (o_m_tdata[17:15] !== want.w2) report("width_2", o_m_tdata[17:15], want.w2);
                if (o_m_tdata[20:18] !== want.w3) report("width_3", o_m_tdata[20:18], want.w3);
                if (o_m_tdata[23:21] !== want.w4) report("width_4", o_m_tdata[23:21], want.w4);
                if (o_m_tdata[26:24] !== want.w5) report("width_5", o_m_tdata[26:24], want.w5);
                if (o_m_tdata[29:27] !== want.elems) begin
                    report("element_count", o_m_tdata[29:27], want.elems);
                end
                if (o_m_tdata[35:30] !== want.total) begin
                    report("total_symbols", o_m_tdata[35:30], want.total);
                end
                if (o_m_tdata[36] !== want.trunc) report("truncated", o_m_tdata[36], want.trunc);
                if (o_m_tlast !== want.last) report("last_item", o_m_tlast, want.last);
            end
        end
    end

    // Hard limit on the run; far above the slowest legal message sequence.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    msg_row_t directed [8] = '{
        // Empty message closed by an invalid code: start A, check and stop only.
        '{"", 1, 0, 3},
        // Two digits alone start in set C as one pair.
        '{"12", 0, 0, 4},
        '{"1234", 0, 1, -1},
        // Lower case, then a control character forces a switch to set A.
        '{"ab\001x", 0, 2, -1},
        // Hash as FNC1, all four function codes and NUL, with the unused link mode.
        '{"#\201\202\203\204\200", 0, 3, -1},
        // Codes 255 and 133 are dropped, 127 is the top ASCII value.
        '{"\177\377\205A", 0, 0, -1},
        '{"\00112345", 0, 1, -1},
        '{"9z", 1, 2, -1}
    };

    initial begin
        int total_before, len, pick;
        logic [7:0] c;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_wen   = 1'b0;
        i_cfg_wdata = '0;
        link_mode   = '0;
        msg_overflow = 1'b0;
        bars_queued = 0;
        error_count = 0;
        counted_chars = 0;
        calm = 1'b0;
        stall_left = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed messages, each under its own link mode.
        foreach (directed[r]) begin
            if (directed[r].link != link_mode) write_link(2'(directed[r].link));
            total_before = bars_queued;
            len = directed[r].text.len();
            for (int i = 0; i < len; i++) begin
                send_char(directed[r].text[i], !directed[r].null_end && i == len - 1);
            end
            if (directed[r].null_end) send_char(8'd0, 1'b1);
            if (directed[r].want_total >= 0 &&
                bars_queued - total_before != directed[r].want_total + 2) begin
                report("items of a directed message", bars_queued - total_before,
                       directed[r].want_total + 2);
            end
        end

        // Random messages; link mode changes now and then, always while idle.
        while (counted_chars < 250) begin
            if (counted_chars > 210) calm = 1'b1;
            if ($urandom_range(0, 5) == 0) write_link(2'($urandom_range(0, 3)));
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // Too long for the character buffer.
                len = $urandom_range(CHAR_DEPTH + 1, CHAR_DEPTH + 6);
                for (int i = 0; i < len; i++) send_char(random_char(), i == len - 1);
            end else if (pick < 13) begin
                // Lower case and control characters alternate, so every character after the first
                // costs a set switch and the symbol buffer fills first.
                len = $urandom_range(40, CHAR_DEPTH);
                for (int i = 0; i < len; i++) begin
                    c = (i % 2 == 0) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(1, 31));
                    send_char(c, i == len - 1);
                end
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) send_char(random_char(), i == len - 1);
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (pending_bars.size() == 0);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/c128_pkg.sv
rtl/c128_ctrl.sv
rtl/c128_dp.sv
rtl/code128_symbol_encoder.sv
bench/code128_symbol_encoder_tb.sv
